[src/pcf_pkg.sv]
// ----------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants of the pulse count character row framer.
// ----------------------------------------------------------------------------
package pcf_pkg;

  // Widest row position the framer supports (row capacity up to 256).
  localparam int POS_MAX_W = 8;

  // Depth of the command queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Input commands.
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_TERMINATOR  = 1'b0;
  localparam logic CFG_MAX_SECONDS = 1'b1;

  localparam logic [7:0]  TERMINATOR_RESET  = 8'd10;
  localparam logic [15:0] MAX_SECONDS_RESET = 16'd10;

  // One appended character, handed from front to back.
  typedef struct packed {
    logic [7:0]           ch;
    logic                 close;
    logic [POS_MAX_W-1:0] pos;
  } row_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ISSUE,
    BK_SHOW
  } back_state_t;

endpackage

[src/pulse_count_char_row_framer.sv]
// ----------------------------------------------------------------------------
// pulse_count_char_row_framer
// Decodes pulse-burst characters and frames them into rows of bytes.
// ----------------------------------------------------------------------------
// An edge request adds one to a wrapping 8-bit pulse count; a tick request
// after a quiet poll period turns a nonzero count into one character. Each
// request is taken by the front, which stalls only while the four-entry
// character queue is full. The back drains the queue one entry a cycle while
// idle into a single-port row memory; a row-closing character (capacity
// reached, terminator seen, or elapsed seconds above the limit) starts
// readout: per byte, an issue state for the registered read, then a show
// state held by any output stall. row_end marks the last byte. No clearing
// pass is needed after reset. Configuration writes are always ready.
// ----------------------------------------------------------------------------
module pulse_count_char_row_framer import pcf_pkg::*; #(
  parameter int ROW_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_row_byte,
  output logic        out_row_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic     in_accept;
  logic     q_push;
  logic     q_pop;
  logic     q_full;
  logic     q_valid;
  row_cmd_t push_cmd;
  row_cmd_t q_head;

  // Hold input requests only while the queue has no free slot.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !q_full;
  assign cfg_ready = 1'b1;

  pcf_front #(.ROW_CAPACITY(ROW_CAPACITY)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_accept      (in_accept),
    .in_command     (in_command),
    .in_now_seconds (in_now_seconds),
    .cfg_write      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .push           (q_push),
    .push_cmd       (push_cmd)
  );

  // Decouple decoding from readout.
  pcf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .valid    (q_valid),
    .head     (q_head)
  );

  pcf_back #(.ROW_CAPACITY(ROW_CAPACITY)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_row_byte (out_row_byte),
    .out_row_end  (out_row_end)
  );

`ifndef SYNTHESIS
  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("character queue overflow");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("character queue underflow");

  // After the last byte of a row is taken, readout stops.
  a_row_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_row_end) |=> !out_valid)
    else $error("readout continued past row end");
`endif

endmodule

[src/pcf_front.sv]
// ----------------------------------------------------------------------------
// pcf_front
// Counts pulses, decodes characters on quiet ticks and decides row closing.
// ----------------------------------------------------------------------------
module pcf_front import pcf_pkg::*; #(
  parameter int ROW_CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_accept,
  input  logic        in_command,
  input  logic [31:0] in_now_seconds,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  output logic        push,
  output row_cmd_t    push_cmd
);

  localparam int IW = $clog2(ROW_CAPACITY);

  logic [7:0]    count_r, count_nxt;
  logic          mark_r, mark_nxt;
  logic [IW-1:0] fill_r, fill_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [7:0]    term_r;
  logic [15:0]   max_sec_r;

  logic [31:0] start_eff;
  logic [31:0] elapsed;
  logic        close;

  assign start_eff = (fill_r == '0) ? in_now_seconds : start_r;
  assign elapsed   = in_now_seconds - start_eff;
  assign close     = (fill_r == IW'(ROW_CAPACITY - 1)) || (count_r == term_r) ||
                     (elapsed > {16'd0, max_sec_r});

  always_comb begin
    count_nxt = count_r;
    mark_nxt  = mark_r;
    fill_nxt  = fill_r;
    start_nxt = start_r;
    push      = 1'b0;
    push_cmd.ch    = count_r;
    push_cmd.close = close;
    push_cmd.pos   = POS_MAX_W'(fill_r);
    if (in_accept) begin
      if (in_command == CMD_EDGE) begin
        count_nxt = count_r + 8'd1;
        mark_nxt  = 1'b1;
      end else if (mark_r) begin
        mark_nxt = 1'b0;
      end else if (count_r != 8'd0) begin
        // Quiet period ends a burst: emit one character.
        push      = 1'b1;
        count_nxt = 8'd0;
        start_nxt = start_eff;
        fill_nxt  = close ? '0 : fill_r + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 8'd0;
      mark_r    <= 1'b0;
      fill_r    <= '0;
      start_r   <= 32'd0;
      term_r    <= TERMINATOR_RESET;
      max_sec_r <= MAX_SECONDS_RESET;
    end else begin
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
      fill_r  <= fill_nxt;
      start_r <= start_nxt;
      if (cfg_write) begin
        case (cfg_index)
          CFG_TERMINATOR:  term_r    <= cfg_data[7:0];
          CFG_MAX_SECONDS: max_sec_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

[src/pcf_queue.sv]
// ----------------------------------------------------------------------------
// pcf_queue
// Short FIFO of appended characters between front and back.
// ----------------------------------------------------------------------------
module pcf_queue import pcf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  row_cmd_t push_cmd,
  input  logic     pop,
  output logic     full,
  output logic     valid,
  output row_cmd_t head
);

  row_cmd_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W + 1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W + 1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[src/pcf_back.sv]
// ----------------------------------------------------------------------------
// pcf_back
// Stores row characters and reads a closed row out byte by byte.
// ----------------------------------------------------------------------------
module pcf_back import pcf_pkg::*; #(
  parameter int ROW_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  row_cmd_t   q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_row_byte,
  output logic       out_row_end
);

  localparam int IW = $clog2(ROW_CAPACITY);

  logic [7:0]    row_mem [ROW_CAPACITY];
  logic [7:0]    rdata_r;
  back_state_t   state_r, state_nxt;
  logic [IW-1:0] rd_addr_r, rd_addr_nxt;
  logic [IW-1:0] rd_last_r, rd_last_nxt;
  logic          wr_en;
  logic          rd_en;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[q_head.pos[IW-1:0]] <= q_head.ch;
    end
    if (rd_en) begin
      rdata_r <= row_mem[rd_addr_r];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    rd_addr_nxt = rd_addr_r;
    rd_last_nxt = rd_last_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_valid   = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          wr_en = 1'b1;
          if (q_head.close) begin
            rd_addr_nxt = '0;
            rd_last_nxt = q_head.pos[IW-1:0];
            state_nxt   = BK_ISSUE;
          end
        end
      end
      BK_ISSUE: begin
        rd_en     = 1'b1;
        state_nxt = BK_SHOW;
      end
      BK_SHOW: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (rd_addr_r == rd_last_r) begin
            state_nxt = BK_IDLE;
          end else begin
            rd_addr_nxt = rd_addr_r + IW'(1);
            state_nxt   = BK_ISSUE;
          end
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  assign out_row_byte = rdata_r;
  assign out_row_end  = (rd_addr_r == rd_last_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      rd_addr_r <= '0;
      rd_last_r <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_addr_r <= rd_addr_nxt;
      rd_last_r <= rd_last_nxt;
    end
  end

endmodule
